>>> sv/lmtc_pkg.sv
package lmtc_pkg;

    // Field and state widths
    localparam int TIMER_W     = 14;
    localparam int VLT_W       = 11;
    localparam int LINE_W      = 8;
    localparam int STAT_EN_W   = 4;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;

    // Mode durations in time units
    localparam logic [TIMER_W:0] T_OAM    = (TIMER_W + 1)'(160);
    localparam logic [TIMER_W:0] T_VRAM   = (TIMER_W + 1)'(344);
    localparam logic [TIMER_W:0] T_HBLANK = (TIMER_W + 1)'(408);
    localparam logic [TIMER_W:0] T_VBLANK = (TIMER_W + 1)'(9120);
    localparam logic [VLT_W:0]   T_VLINE  = (VLT_W + 1)'(912);

    localparam logic [TIMER_W-1:0] TIMER_RESET   = TIMER_W'(9119);
    localparam logic [LINE_W-1:0]  VISIBLE_LINES = LINE_W'(144);
    localparam logic [LINE_W-1:0]  START_LINE    = LINE_W'(153);

    // STAT interrupt source enable bits
    localparam int STAT_SRC_HBLANK = 0;
    localparam int STAT_SRC_VBLANK = 1;
    localparam int STAT_SRC_OAM    = 2;
    localparam int STAT_SRC_MATCH  = 3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DISPLAY_ON      = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STAT_INT_ENABLE = 1'b1;

    // Item opcodes
    localparam logic OP_TICK      = 1'b0;
    localparam logic OP_WRITE_LYC = 1'b1;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_VRAM   = 2'd3
    } mode_t;

    typedef struct packed {
        logic              opcode;
        logic [7:0]        elapsed;
        logic [LINE_W-1:0] compare_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        lcd_mode;
        logic [LINE_W-1:0] current_line;
        logic              line_match;
        logic              stat_irq;
        logic              vblank_irq;
        logic              draw_request;
    } out_item_t;

    typedef struct packed {
        logic                 display_on;
        logic [STAT_EN_W-1:0] stat_int_enable;
    } cfg_t;

endpackage

>>> sv/lmtc_cfg.sv
module lmtc_cfg
    import lmtc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Take a register write on each transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DISPLAY_ON: begin
                    cfg_reg.display_on <= cfg_data[0];
                end
                CFG_STAT_INT_ENABLE: begin
                    cfg_reg.stat_int_enable <= cfg_data[STAT_EN_W-1:0];
                end
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

endmodule

>>> sv/lmtc_seq.sv
module lmtc_seq
    import lmtc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step_en,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    mode_t               mode_reg, mode_next;
    logic [TIMER_W-1:0]  timer_reg, timer_next;
    logic [LINE_W-1:0]   vlc_reg, vlc_next;
    logic [VLT_W-1:0]    vlt_reg, vlt_next;
    logic [LINE_W-1:0]   line_reg, line_next;
    logic                match_reg, match_next;
    logic [LINE_W-1:0]   lyc_reg, lyc_next;
    logic                recheck_reg, recheck_next;

    logic [TIMER_W:0]    timer_sum;
    logic [TIMER_W:0]    timer_tmp;
    logic [VLT_W:0]      vlt_sum;
    logic [LINE_W-1:0]   vlc_inc;
    logic                load;
    logic [LINE_W-1:0]   load_val;
    logic                stat;
    logic                vbl;
    logic                draw;

    assign timer_sum = {1'b0, timer_reg} + (TIMER_W + 1)'(item.elapsed);
    assign vlt_sum   = {1'b0, vlt_reg} + (VLT_W + 1)'(item.elapsed);
    assign vlc_inc   = vlc_reg + LINE_W'(1);

    // Work out the state after one item and its pulses
    always_comb begin
        mode_next    = mode_reg;
        timer_next   = timer_reg;
        vlc_next     = vlc_reg;
        vlt_next     = vlt_reg;
        line_next    = line_reg;
        match_next   = match_reg;
        lyc_next     = lyc_reg;
        recheck_next = recheck_reg;
        timer_tmp    = timer_sum;
        load         = 1'b0;
        load_val     = line_reg;
        stat         = 1'b0;
        vbl          = 1'b0;
        draw         = 1'b0;

        if (item.opcode == OP_WRITE_LYC) begin
            lyc_next     = item.compare_value;
            recheck_next = 1'b1;
        end else if (!cfg.display_on) begin
            mode_next  = MODE_VBLANK;
            match_next = 1'b0;
            timer_next = TIMER_RESET;
            vlc_next   = '0;
            vlt_next   = '0;
        end else begin
            // Recompare LY against a freshly written LYC
            if (recheck_reg) begin
                recheck_next = 1'b0;
                match_next   = (line_reg == lyc_reg);
                stat         = cfg.stat_int_enable[STAT_SRC_MATCH] & match_next;
            end

            // Advance the mode timer
            case (mode_reg)
                MODE_OAM: begin
                    if (timer_sum > T_OAM) begin
                        timer_tmp = timer_sum - T_OAM;
                        mode_next = MODE_VRAM;
                    end
                end
                MODE_VRAM: begin
                    if (timer_sum > T_VRAM) begin
                        timer_tmp = timer_sum - T_VRAM;
                        mode_next = MODE_HBLANK;
                    end
                end
                MODE_HBLANK: begin
                    if (timer_sum > T_HBLANK) begin
                        timer_tmp = timer_sum - T_HBLANK;
                        vlc_next  = vlc_inc;
                        mode_next = (vlc_inc == VISIBLE_LINES) ? MODE_VBLANK : MODE_OAM;
                    end
                end
                default: begin
                    if (timer_sum > T_VBLANK) begin
                        timer_tmp = timer_sum - T_VBLANK;
                        mode_next = MODE_OAM;
                    end else if (vlt_sum > T_VLINE) begin
                        vlt_next = VLT_W'(vlt_sum - T_VLINE);
                        load     = 1'b1;
                        load_val = line_reg + LINE_W'(1);
                    end else begin
                        vlt_next = vlt_sum[VLT_W-1:0];
                    end
                end
            endcase
            timer_next = timer_tmp[TIMER_W-1:0];

            // Mode entry actions
            if (mode_next != mode_reg) begin
                case (mode_next)
                    MODE_OAM: begin
                        stat = stat | cfg.stat_int_enable[STAT_SRC_OAM];
                        load = 1'b1;
                        if (mode_reg == MODE_VBLANK) begin
                            vlc_next = '0;
                            load_val = '0;
                        end else begin
                            load_val = line_reg + LINE_W'(1);
                        end
                    end
                    MODE_HBLANK: begin
                        stat = stat | cfg.stat_int_enable[STAT_SRC_HBLANK];
                        draw = 1'b1;
                    end
                    MODE_VBLANK: begin
                        stat     = stat | cfg.stat_int_enable[STAT_SRC_VBLANK];
                        vbl      = 1'b1;
                        vlt_next = '0;
                    end
                    default: begin
                        stat = stat;
                    end
                endcase
            end

            // Load LY and refresh the coincidence flag
            if (load) begin
                line_next  = load_val;
                match_next = (load_val == lyc_reg);
                stat       = stat | (cfg.stat_int_enable[STAT_SRC_MATCH] & match_next);
            end
        end
    end

    assign result.lcd_mode     = mode_next;
    assign result.current_line = line_next;
    assign result.line_match   = match_next;
    assign result.stat_irq     = stat;
    assign result.vblank_irq   = vbl;
    assign result.draw_request = draw;

    // Hold the sequencer state, advance once per item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_VBLANK;
            timer_reg   <= TIMER_RESET;
            vlc_reg     <= '0;
            vlt_reg     <= '0;
            line_reg    <= START_LINE;
            match_reg   <= 1'b0;
            lyc_reg     <= '0;
            recheck_reg <= 1'b0;
        end else if (step_en) begin
            mode_reg    <= mode_next;
            timer_reg   <= timer_next;
            vlc_reg     <= vlc_next;
            vlt_reg     <= vlt_next;
            line_reg    <= line_next;
            match_reg   <= match_next;
            lyc_reg     <= lyc_next;
            recheck_reg <= recheck_next;
        end
    end

`ifndef SYNTH
    a_lcd_off_forces_vblank: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && item.opcode == OP_TICK && !cfg.display_on) |=>
        (mode_reg == MODE_VBLANK && timer_reg == TIMER_RESET && !match_reg))
        else $error("lcd off tick did not force vblank");

    a_vblank_irq_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && result.vblank_irq) |=> (mode_reg == MODE_VBLANK && vlt_reg == '0))
        else $error("vblank interrupt without vblank entry");

    a_draw_in_hblank: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && result.draw_request) |=> (mode_reg == MODE_HBLANK))
        else $error("draw request outside hblank entry");

    a_write_keeps_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && item.opcode == OP_WRITE_LYC) |=> ($stable(mode_reg) && recheck_reg))
        else $error("compare line write disturbed the mode");

    a_visible_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg != MODE_VBLANK) |-> (vlc_reg < VISIBLE_LINES))
        else $error("visible line count out of range");
`endif

endmodule

>>> sv/lcd_mode_timing_controller.sv
// Channel   Direction  Payload      Handshake
// s_        in         in_item_t    s_valid / s_ready
// m_        out        out_item_t   m_valid / m_ready
// cfg_      in         index, data  cfg_valid / cfg_ready (always ready)
//
// One item per cycle sustained while the result side keeps m_ready high.
// The item register feeds one pass of timer add, compare and subtract into the
// result register; state is updated as the item moves into the result register.
// Synchronous active-low reset puts the sequencer in vblank at line 153.
// A stalled result holds the item register; s_ready follows free space in the pipe.
module lcd_mode_timing_controller
    import lmtc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t      cfg;
    in_item_t  item_reg;
    logic      item_valid_reg;
    out_item_t result;
    out_item_t out_reg;
    logic      out_valid_reg;
    logic      advance;

    lmtc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lmtc_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Move the item on when the result slot is free or being drained
    assign advance = item_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !item_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_ready) begin
            item_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

>>> tb/lcd_mode_timing_checker.sv
`timescale 1ns / 100ps

module lcd_mode_timing_checker
    import lmtc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  in_item_t               s_data,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  out_item_t              m_data,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatch_count,
    output int                     pending_results,
    output int                     results_checked,
    output int                     frames_seen,
    output int                     draws_seen
);

    // Shadow copy of the sequencer state and its registers
    logic                 lcd_on_q;
    logic [STAT_EN_W-1:0] stat_en_q;
    mode_t                mode_q;
    logic [TIMER_W-1:0]   timer_q;
    logic [LINE_W-1:0]    vis_lines_q;
    logic [VLT_W-1:0]     vline_timer_q;
    logic [LINE_W-1:0]    ly_q;
    logic                 match_q;
    logic [LINE_W-1:0]    lyc_q;
    logic                 recheck_q;

    out_item_t expected_status[$];

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("%0t ns: MISMATCH %s", $time, msg);
    endtask

    // Load LY and refresh the coincidence flag; return the STAT post it causes
    function automatic logic load_ly(input logic [LINE_W-1:0] value);
        ly_q    = value;
        match_q = (ly_q == lyc_q);
        return match_q & stat_en_q[STAT_SRC_MATCH];
    endfunction

    // Advance the shadow sequencer by one transfer and return its status
    function automatic out_item_t step_timing(input in_item_t tx);
        out_item_t        res;
        logic             stat;
        logic             vbl;
        logic             draw;
        logic [TIMER_W:0] tsum;
        logic [VLT_W:0]   vsum;
        mode_t            nxt;
        stat = 1'b0;
        vbl  = 1'b0;
        draw = 1'b0;
        if (tx.opcode == OP_WRITE_LYC) begin
            lyc_q     = tx.compare_value;
            recheck_q = 1'b1;
        end else if (!lcd_on_q) begin
            // LCD off: park in vblank, keep LY and any pending recheck
            mode_q        = MODE_VBLANK;
            match_q       = 1'b0;
            timer_q       = TIMER_RESET;
            vis_lines_q   = '0;
            vline_timer_q = '0;
        end else begin
            if (recheck_q) begin
                recheck_q = 1'b0;
                stat      = stat | load_ly(ly_q);
            end
            tsum = {1'b0, timer_q} + (TIMER_W + 1)'(tx.elapsed);
            nxt  = mode_q;
            case (mode_q)
                MODE_OAM: begin
                    if (tsum > T_OAM) begin
                        tsum = tsum - T_OAM;
                        nxt  = MODE_VRAM;
                    end
                end
                MODE_VRAM: begin
                    if (tsum > T_VRAM) begin
                        tsum = tsum - T_VRAM;
                        nxt  = MODE_HBLANK;
                    end
                end
                MODE_HBLANK: begin
                    if (tsum > T_HBLANK) begin
                        tsum        = tsum - T_HBLANK;
                        vis_lines_q = vis_lines_q + LINE_W'(1);
                        nxt = (vis_lines_q == VISIBLE_LINES) ? MODE_VBLANK : MODE_OAM;
                    end
                end
                default: begin
                    // The tick that ends vblank leaves the line timer alone
                    if (tsum > T_VBLANK) begin
                        tsum = tsum - T_VBLANK;
                        nxt  = MODE_OAM;
                    end else begin
                        vsum = {1'b0, vline_timer_q} + (VLT_W + 1)'(tx.elapsed);
                        if (vsum > T_VLINE) begin
                            vsum = vsum - T_VLINE;
                            stat = stat | load_ly(ly_q + LINE_W'(1));
                        end
                        vline_timer_q = vsum[VLT_W-1:0];
                    end
                end
            endcase
            timer_q = tsum[TIMER_W-1:0];

            // Mode entry side effects
            if (nxt != mode_q) begin
                case (nxt)
                    MODE_OAM: begin
                        stat = stat | stat_en_q[STAT_SRC_OAM];
                        if (mode_q == MODE_VBLANK) begin
                            vis_lines_q = '0;
                            stat        = stat | load_ly('0);
                        end else begin
                            stat = stat | load_ly(ly_q + LINE_W'(1));
                        end
                    end
                    MODE_HBLANK: begin
                        stat = stat | stat_en_q[STAT_SRC_HBLANK];
                        draw = 1'b1;
                    end
                    MODE_VBLANK: begin
                        stat          = stat | stat_en_q[STAT_SRC_VBLANK];
                        vbl           = 1'b1;
                        vline_timer_q = '0;
                    end
                    default: ;
                endcase
                mode_q = nxt;
            end
        end
        res.lcd_mode     = mode_q;
        res.current_line = ly_q;
        res.line_match   = match_q;
        res.stat_irq     = stat;
        res.vblank_irq   = vbl;
        res.draw_request = draw;
        return res;
    endfunction

    // Watch the three channels: registers, result check, then prediction
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            lcd_on_q        = 1'b0;
            stat_en_q       = '0;
            mode_q          = MODE_VBLANK;
            timer_q         = TIMER_RESET;
            vis_lines_q     = '0;
            vline_timer_q   = '0;
            ly_q            = START_LINE;
            match_q         = 1'b0;
            lyc_q           = '0;
            recheck_q       = 1'b0;
            mismatch_count  = 0;
            results_checked = 0;
            frames_seen     = 0;
            draws_seen      = 0;
            expected_status.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DISPLAY_ON:      lcd_on_q  = cfg_data[0];
                    CFG_STAT_INT_ENABLE: stat_en_q = cfg_data[STAT_EN_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_status.size() == 0) begin
                    report_mismatch($sformatf("result with nothing outstanding: %h", m_data));
                end else begin
                    want = expected_status.pop_front();
                    if (m_data.lcd_mode !== want.lcd_mode)
                        report_mismatch($sformatf("result %0d lcd_mode got %0d expected %0d",
                            results_checked, m_data.lcd_mode, want.lcd_mode));
                    if (m_data.current_line !== want.current_line)
                        report_mismatch($sformatf("result %0d current_line got %0d expected %0d",
                            results_checked, m_data.current_line, want.current_line));
                    if (m_data.line_match !== want.line_match)
                        report_mismatch($sformatf("result %0d line_match got %0d expected %0d",
                            results_checked, m_data.line_match, want.line_match));
                    if (m_data.stat_irq !== want.stat_irq)
                        report_mismatch($sformatf("result %0d stat_irq got %0d expected %0d",
                            results_checked, m_data.stat_irq, want.stat_irq));
                    if (m_data.vblank_irq !== want.vblank_irq)
                        report_mismatch($sformatf("result %0d vblank_irq got %0d expected %0d",
                            results_checked, m_data.vblank_irq, want.vblank_irq));
                    if (m_data.draw_request !== want.draw_request)
                        report_mismatch($sformatf("result %0d draw_request got %0d expected %0d",
                            results_checked, m_data.draw_request, want.draw_request));
                    frames_seen += want.vblank_irq;
                    draws_seen  += want.draw_request;
                end
                results_checked++;
            end
            if (s_valid && s_ready)
                expected_status.push_back(step_timing(s_data));
        end
        pending_results = expected_status.size();
    end

endmodule

>>> tb/lcd_mode_timing_controller_tb.sv
`timescale 1ns / 100ps

module lcd_mode_timing_controller_tb;
    import lmtc_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 80;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    in_item_t               s_data;
    logic                   m_valid;
    logic                   m_ready;
    out_item_t              m_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int mismatch_count;
    int pending_results;
    int results_checked;
    int frames_seen;
    int draws_seen;

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_req;
    int held_cycles;
    int cycle_count;
    int items_sent;
    int random_sent;
    int settings_used;

    lcd_mode_timing_controller u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lcd_mode_timing_checker u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .frames_seen     (frames_seen),
        .draws_seen      (draws_seen)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d results outstanding",
                    cycle_count, pending_results);
                $display("lcd_mode_timing_controller_tb: done, errors");
                $finish;
            end
        end
    end

    // Result side: random back-pressure, plus a long hold-off on request
    initial begin
        m_ready     = 1'b0;
        held_cycles = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) begin
                    @(negedge aclk);
                    held_cycles++;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Write one register and wait for the transfer
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Offer one input after a random gap; return once it has transferred
    task automatic send_item(input in_item_t tx);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= tx;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_tick(input logic [7:0] elapsed);
        in_item_t tx;
        tx.opcode        = OP_TICK;
        tx.elapsed       = elapsed;
        tx.compare_value = 8'($urandom_range(255));
        send_item(tx);
    endtask

    task automatic send_lyc(input logic [LINE_W-1:0] value);
        in_item_t tx;
        tx.opcode        = OP_WRITE_LYC;
        tx.elapsed       = 8'($urandom_range(255));
        tx.compare_value = value;
        send_item(tx);
    endtask

    // Drop valid and hold until every predicted result has been checked
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results != 0) @(negedge aclk);
    endtask

    // Stimulus and verdict
    initial begin
        in_item_t             tx;
        int                   r;
        int                   n_items;
        logic                 lcd_on;
        logic [STAT_EN_W-1:0] stat_en;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        hold_req      = 1'b0;
        items_sent    = 0;
        random_sent   = 0;
        settings_used = 0;
        send_idle_pct = 32;
        recv_idle_pct = 48;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: leave vblank, walk a line, rechecks, LCD off and back on
        write_reg(CFG_DISPLAY_ON, 4'd1);
        write_reg(CFG_STAT_INT_ENABLE, 4'hF);
        settings_used++;
        send_lyc(8'h00);
        send_tick(8'd0);
        send_tick(8'd1);
        send_tick(8'd255);
        send_tick(8'd255);
        send_tick(8'd255);
        send_tick(8'd255);
        send_tick(8'd255);
        send_lyc(8'hFF);
        send_lyc(8'h01);
        send_tick(8'd2);
        send_tick(8'd128);
        wait_idle();
        write_reg(CFG_DISPLAY_ON, 4'd0);
        settings_used++;
        send_tick(8'hAA);
        send_lyc(8'h00);
        send_tick(8'h55);
        wait_idle();
        write_reg(CFG_DISPLAY_ON, 4'd1);
        settings_used++;
        send_tick(8'd3);

        // Random phases, each under its own register setting
        for (int p = 0; p < 7; p++) begin
            case (p)
                0: begin lcd_on = 1'b1; stat_en = 4'hF; n_items = 300; end
                1: begin lcd_on = 1'b0; stat_en = 4'hA; n_items = 25;  end
                2: begin lcd_on = 1'b1; stat_en = 4'h5; n_items = 300; end
                3: begin lcd_on = 1'b1; stat_en = 4'h0; n_items = 100; end
                4: begin lcd_on = 1'b0; stat_en = 4'h0; n_items = 25;  end
                5: begin lcd_on = 1'b1; stat_en = 4'h8; n_items = 150; end
                default: begin lcd_on = 1'b1; stat_en = 4'h7; n_items = 130; end
            endcase
            wait_idle();
            if (p < 2) begin
                send_idle_pct = 32;
                recv_idle_pct = 48;
            end else if (p < 4) begin
                send_idle_pct = 48;
                recv_idle_pct = 32;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(CFG_DISPLAY_ON, CFG_DATA_W'(lcd_on));
            write_reg(CFG_STAT_INT_ENABLE, stat_en);
            settings_used++;
            for (int i = 0; i < n_items; i++) begin
                // Long receiver hold-off while inputs keep coming
                if (p == 0 && i == 100)
                    hold_req = 1'b1;
                // Sender pause until the pipe has emptied
                if (p == 2 && i == 150)
                    wait_idle();
                // Mostly long ticks to get through whole frames; some LYC writes
                r = $urandom_range(99);
                tx.opcode        = (r < 8) ? OP_WRITE_LYC : OP_TICK;
                tx.elapsed       = (r < 70) ? 8'($urandom_range(255, 192))
                                            : 8'($urandom_range(255));
                tx.compare_value = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                            : 8'($urandom_range(153));
                send_item(tx);
                random_sent++;
            end
        end

        // Drain and let the pipe settle
        wait_idle();
        repeat (8) @(negedge aclk);

        $display("covered %0d transfers in (%0d random) under %0d register settings,",
            items_sent, random_sent, settings_used);
        $display("%0d results checked, %0d vblank entries, %0d line draws, held off %0d cycles",
            results_checked, frames_seen, draws_seen, held_cycles);
        if (mismatch_count == 0) begin
            $display("lcd_mode_timing_controller_tb: done, clean");
        end else begin
            $display("lcd_mode_timing_controller_tb: done, errors");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/lmtc_pkg.sv
sv/lmtc_cfg.sv
sv/lmtc_seq.sv
sv/lcd_mode_timing_controller.sv
tb/lcd_mode_timing_checker.sv
tb/lcd_mode_timing_controller_tb.sv
